[rtl/core/indexed_list_table_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the indexed list table unit
// Implication checks, each clocked on the rising edge and muted during reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_TABLE_UNIT_ASSERT_SVH
`define INDEXED_LIST_TABLE_UNIT_ASSERT_SVH

// same-cycle implication
`define ILT_ASSERT_IMP(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILT_ASSERT_NXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ilt_pkg.sv]
// ---------------------------------------------------------------------------
// ilt_pkg
// Shared types and constants for the indexed list table unit: request and
// status codes, controller states and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none

package ilt_pkg;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;

  localparam logic [POS_W-1:0] NO_POS = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_REMOVE = 3'd1,
    REQ_FIND   = 3'd2,
    REQ_READ   = 3'd3,
    REQ_WRITE  = 3'd4,
    REQ_PUSH   = 3'd5,
    REQ_POP    = 3'd6,
    REQ_NOP    = 3'd7
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHUP_CHK,
    S_SHUP_WR,
    S_SHDN_CHK,
    S_SHDN_WR,
    S_FIND_CHK,
    S_FIND_CMP,
    S_READ_WAIT,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_POS,
    IDX_LOAD_CNT,
    IDX_LOAD_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_IDX_P1,
    RD_POS,
    RD_CNT_M1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_IDX_RDATA,
    WR_POS_WORD,
    WR_CNT_WORD
  } wr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_INIT,
    RES_WORD,
    RES_FOUND
  } res_op_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    res_op_t res_op;
    logic    out_load;
  } ilt_cmd_t;

  typedef struct packed {
    req_t    req;
    status_t err;
    logic    idx_at_pos;
    logic    idx_last;
    logic    idx_end;
    logic    match;
    logic    out_free;
  } ilt_sts_t;

endpackage

`default_nettype wire

[rtl/core/indexed_list_table_unit.sv]
// ---------------------------------------------------------------------------
// indexed_list_table_unit
// Bounded ordered list of signed 32-bit words with insert, remove, find,
// read, write, push and pop requests, one result word per request.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries req_type, position, word_in.
//   Output channel out_valid/out_stall carries status, word_out, found_at
//   and count_now. A word moves when valid is high and stall is low.
//   One request is in flight at a time; the next is taken once the result
//   has entered the output register, which may still be waiting.
//   After acceptance each request is decoded and range-checked. Write,
//   push, errors and req 7 then pass to the output register, while read
//   and pop first read the word memory. Insert moves the words from
//   position to count - 1 up one place, starting at the top; remove moves
//   the words after position down one place; find reads and compares
//   entries from index 0 until a match or the end of the list.
//   The word memory has a single port: each shifted word is one read
//   then one write, each searched word one read then one compare.
//   Reset empties the list; stored words are left as they are.
//   A stalled result is held; the block finishes its current request and
//   then waits with in_stall high until the output register frees.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ilt_pkg::REQ_W-1:0]  req_type,
  input  logic [ilt_pkg::POS_W-1:0]  position,
  input  logic [ilt_pkg::WORD_W-1:0] word_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ilt_pkg::STAT_W-1:0] status,
  output logic [ilt_pkg::WORD_W-1:0] word_out,
  output logic [ilt_pkg::POS_W-1:0]  found_at,
  output logic [ilt_pkg::POS_W-1:0]  count_now
);
  import ilt_pkg::*;

  ilt_cmd_t cmd;
  ilt_sts_t sts;

  ilt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ilt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_type  (req_type),
    .position  (position),
    .word_in   (word_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .word_out  (word_out),
    .found_at  (found_at),
    .count_now (count_now)
  );

`include "indexed_list_table_unit_assert.svh"

  `ILT_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall,
    "request accepted but unit not busy next cycle")
  `ILT_ASSERT_IMP(a_err_word_zero, clk, rst, out_valid && (status != ST_OK),
    word_out == '0, "error result carries a non-zero word")
  `ILT_ASSERT_IMP(a_err_no_pos, clk, rst, out_valid && (status != ST_OK),
    found_at == NO_POS, "error result carries a found position")
  `ILT_ASSERT_IMP(a_port_single, clk, rst, cmd.wr_en, !cmd.rd_en,
    "memory read and write issued together")

endmodule

`default_nettype wire

[rtl/core/ilt_ctrl.sv]
// ---------------------------------------------------------------------------
// ilt_ctrl
// Sequencer for the list table: decodes each request and steps the datapath
// through shifts, searches and memory reads.
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ilt_pkg::ilt_sts_t sts,
  output ilt_pkg::ilt_cmd_t cmd
);
  import ilt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.err != ST_OK) begin
          state_next = S_DONE;
        end else begin
          case (sts.req)
            REQ_INSERT: state_next = S_SHUP_CHK;
            REQ_REMOVE: state_next = S_SHDN_CHK;
            REQ_FIND:   state_next = S_FIND_CHK;
            REQ_READ:   state_next = S_READ_WAIT;
            REQ_POP:    state_next = S_READ_WAIT;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_SHUP_CHK:  state_next = sts.idx_at_pos ? S_DONE : S_SHUP_WR;
      S_SHUP_WR:   state_next = S_SHUP_CHK;
      S_SHDN_CHK:  state_next = sts.idx_last ? S_DONE : S_SHDN_WR;
      S_SHDN_WR:   state_next = S_SHDN_CHK;
      S_FIND_CHK:  state_next = sts.idx_end ? S_DONE : S_FIND_CMP;
      S_FIND_CMP:  state_next = sts.match ? S_DONE : S_FIND_CHK;
      S_READ_WAIT: state_next = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = rst || (state != S_IDLE);
    cmd          = '0;
    cmd.idx_op   = IDX_HOLD;
    cmd.rd_sel   = RD_IDX;
    cmd.wr_sel   = WR_IDX_RDATA;
    cmd.cnt_op   = CNT_HOLD;
    cmd.res_op   = RES_NONE;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.res_op = RES_INIT;
        if (sts.err == ST_OK) begin
          case (sts.req)
            REQ_INSERT: cmd.idx_op = IDX_LOAD_CNT;
            REQ_REMOVE: cmd.idx_op = IDX_LOAD_POS;
            REQ_FIND:   cmd.idx_op = IDX_LOAD_ZERO;
            REQ_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_POS;
            end
            REQ_WRITE: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_POS_WORD;
            end
            REQ_PUSH: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = WR_CNT_WORD;
              cmd.cnt_op = CNT_INC;
            end
            REQ_POP: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_CNT_M1;
              cmd.cnt_op = CNT_DEC;
            end
            default: cmd.idx_op = IDX_HOLD;
          endcase
        end
      end
      S_SHUP_CHK: begin
        if (sts.idx_at_pos) begin
          // gap is open: drop the new word in
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_POS_WORD;
          cmd.cnt_op = CNT_INC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
        end
      end
      S_SHUP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_IDX_RDATA;
        cmd.idx_op = IDX_DEC;
      end
      S_SHDN_CHK: begin
        if (sts.idx_last) begin
          cmd.cnt_op = CNT_DEC;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
        end
      end
      S_SHDN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_IDX_RDATA;
        cmd.idx_op = IDX_INC;
      end
      S_FIND_CHK: begin
        if (!sts.idx_end) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
        end
      end
      S_FIND_CMP: begin
        if (sts.match) begin
          cmd.res_op = RES_FOUND;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_READ_WAIT: begin
        cmd.res_op = RES_WORD;
      end
      S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/ilt_dp.sv]
// ---------------------------------------------------------------------------
// ilt_dp
// Datapath for the list table: word memory, fill count, walking index,
// range checks, result registers and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ilt_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ilt_pkg::ilt_cmd_t            cmd,
  output ilt_pkg::ilt_sts_t            sts,
  input  logic [ilt_pkg::REQ_W-1:0]    req_type,
  input  logic [ilt_pkg::POS_W-1:0]    position,
  input  logic [ilt_pkg::WORD_W-1:0]   word_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ilt_pkg::STAT_W-1:0]   status,
  output logic [ilt_pkg::WORD_W-1:0]   word_out,
  output logic [ilt_pkg::POS_W-1:0]    found_at,
  output logic [ilt_pkg::POS_W-1:0]    count_now
);
  import ilt_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rd_data;

  req_t              req_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] word_q;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] pos_c, rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;
  logic [XW-1:0] pos_x, cnt_x, idx_x;
  logic          full;

  status_t           err, res_status;
  logic [WORD_W-1:0] res_word;
  logic [POS_W-1:0]  res_found;

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(count);
  assign idx_x = XW'(idx);
  assign pos_c = pos_x[CW-1:0];
  assign full  = (count == CW'(CAPACITY));

  always_comb begin
    err = ST_OK;
    case (req_q)
      REQ_INSERT: begin
        if (pos_x > cnt_x) begin
          err = ST_RANGE;
        end else if (full) begin
          err = ST_FULL;
        end
      end
      REQ_REMOVE, REQ_READ, REQ_WRITE: begin
        if (pos_x >= cnt_x) begin
          err = ST_RANGE;
        end
      end
      REQ_PUSH: begin
        if (full) begin
          err = ST_FULL;
        end
      end
      REQ_POP: begin
        if (count == '0) begin
          err = ST_EMPTY;
        end
      end
      default: err = ST_OK;
    endcase
  end

  always_comb begin
    sts.req        = req_q;
    sts.err        = err;
    sts.idx_at_pos = (idx_x == pos_x);
    sts.idx_last   = (({1'b0, idx_x} + (XW + 1)'(1)) >= {1'b0, cnt_x});
    sts.idx_end    = (idx_x >= cnt_x);
    sts.match      = (rd_data == word_q);
    sts.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:    rd_addr = idx;
      RD_IDX_M1: rd_addr = idx - CW'(1);
      RD_IDX_P1: rd_addr = idx + CW'(1);
      RD_POS:    rd_addr = pos_c;
      RD_CNT_M1: rd_addr = count - CW'(1);
      default:   rd_addr = idx;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_IDX_RDATA: begin
        wr_addr = idx;
        wr_data = rd_data;
      end
      WR_POS_WORD: begin
        wr_addr = pos_c;
        wr_data = word_q;
      end
      WR_CNT_WORD: begin
        wr_addr = count;
        wr_data = word_q;
      end
      default: begin
        wr_addr = idx;
        wr_data = rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_HOLD:      idx_next = idx;
      IDX_LOAD_POS:  idx_next = pos_c;
      IDX_LOAD_CNT:  idx_next = count;
      IDX_LOAD_ZERO: idx_next = '0;
      IDX_INC:       idx_next = idx + CW'(1);
      IDX_DEC:       idx_next = idx - CW'(1);
      default:       idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_HOLD: count_next = count;
      CNT_INC:  count_next = count + CW'(1);
      CNT_DEC:  count_next = count - CW'(1);
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.load) begin
      req_q  <= req_t'(req_type);
      pos_q  <= position;
      word_q <= word_in;
    end
    case (cmd.res_op)
      RES_INIT: begin
        res_status <= err;
        res_word   <= '0;
        res_found  <= NO_POS;
      end
      RES_WORD:  res_word  <= rd_data;
      RES_FOUND: res_found <= idx_x[POS_W-1:0];
      default:   res_word  <= res_word;
    endcase
  end

  // output register: hold the word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status    <= res_status;
      word_out  <= res_word;
      found_at  <= res_found;
      count_now <= cnt_x[POS_W-1:0];
    end
  end

endmodule

`default_nettype wire
